[rtl/lkv_pkg.sv]
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } lkv_state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             compare;
        logic             update;
        logic             hit;
        logic [OCC_W-1:0] limit;
        logic [KEY_W-1:0] key;
    } lkv_cmd_t;

endpackage

[rtl/lru_key_value_cache_unit.sv]
// Fully associative key/value cache with least-recently-used replacement, built as a row of
// 16 cells held in recency order (cell 0 most recent). Each item passes first through a key
// compare done in parallel in every cell, then a recency shift in which cells take their
// neighbor's entry and cell 0 takes the looked-up or new entry; a get miss shifts nothing.
// The shift step also accepts the next word. A get answers with hit in m_tuser and the value
// (all ones on a miss) in m_tdata through an output register; a get holds in its shift step
// while that register is still full. A put gives no result. The user must write capacity
// through cfg_we/cfg_wdata only while idle (the block does not enforce it); zero acts as 1 and
// values above 16 act as 16. No clearing pass after reset: the cell valid bits reset at once.
module lru_key_value_cache_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,     // capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // lookup_key[31:0], store_value[63:32]
    input  logic        s_tuser,       // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // read_value[31:0]
    output logic        m_tuser        // hit
);

    localparam int N = lkv_pkg::ENTRIES;

    lkv_pkg::lkv_state_t state_reg, state_next;

    logic [lkv_pkg::CAP_W-1:0] capacity_reg;
    logic [lkv_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic                      op_reg;
    logic [lkv_pkg::KEY_W-1:0] key_reg;
    logic [lkv_pkg::VAL_W-1:0] value_reg;

    logic                      m_tvalid_reg;
    logic                      m_tuser_reg;
    logic [lkv_pkg::VAL_W-1:0] m_tdata_reg;

    logic                      accept;
    logic                      finish;
    logic                      out_free;
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] hit_value;
    logic [lkv_pkg::OCC_W-1:0] cap_eff;
    logic [lkv_pkg::OCC_W-1:0] limit;
    lkv_pkg::lkv_cmd_t         cmd;

    logic [lkv_pkg::KEY_W-1:0] key_chain   [0:N];
    logic [lkv_pkg::VAL_W-1:0] value_chain [0:N];
    logic [N:0]                found_chain;
    logic [lkv_pkg::VAL_W-1:0] hval_chain  [0:N];
    logic [N-1:0]              valid_vec;
    logic [N-1:0]              match_vec;

    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign hit       = found_chain[N];
    assign hit_value = hval_chain[N];

    // effective capacity and the last slot kept by a put of a new key
    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = lkv_pkg::OCC_W'(1);
        end else if (32'(capacity_reg) > 32'(N)) begin
            cap_eff = lkv_pkg::OCC_W'(N);
        end else begin
            cap_eff = lkv_pkg::OCC_W'(capacity_reg);
        end
        if (occ_reg >= cap_eff) begin
            limit = cap_eff - lkv_pkg::OCC_W'(1);
        end else begin
            limit = occ_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lkv_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = lkv_pkg::ST_MATCH;
            end
            lkv_pkg::ST_MATCH: begin
                state_next = lkv_pkg::ST_UPDATE;
            end
            lkv_pkg::ST_UPDATE: begin
                if (finish) begin
                    state_next = s_tvalid ? lkv_pkg::ST_MATCH : lkv_pkg::ST_IDLE;
                end
            end
            default: state_next = lkv_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        finish      = 1'b0;
        s_tready    = 1'b0;
        cmd.compare = 1'b0;
        cmd.update  = 1'b0;
        cmd.hit     = hit;
        cmd.limit   = limit;
        cmd.key     = key_reg;
        case (state_reg)
            lkv_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            lkv_pkg::ST_MATCH: begin
                cmd.compare = 1'b1;
            end
            lkv_pkg::ST_UPDATE: begin
                finish     = (op_reg == lkv_pkg::OP_PUT) | out_free;
                s_tready   = finish;
                cmd.update = finish & (hit | (op_reg == lkv_pkg::OP_PUT));
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        occ_next = occ_reg;
        if (cmd.update && !hit) begin
            occ_next = limit + lkv_pkg::OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lkv_pkg::ST_IDLE;
            capacity_reg <= lkv_pkg::CAP_RESET;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            if (finish && op_reg == lkv_pkg::OP_GET) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_tuser;
            key_reg   <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
        end
        if (finish && op_reg == lkv_pkg::OP_GET) begin
            m_tuser_reg <= hit;
            m_tdata_reg <= hit ? hit_value : lkv_pkg::MISS_VALUE;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // the entry entering cell 0: the found value for a get, the new value for a put
    assign key_chain[0]   = key_reg;
    assign value_chain[0] = (op_reg == lkv_pkg::OP_GET) ? hit_value : value_reg;
    assign found_chain[0] = 1'b0;
    assign hval_chain[0]  = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        lkv_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cell_idx      (lkv_pkg::IDX_W'(i)),
            .cmd           (cmd),
            .prev_key      (key_chain[i]),
            .prev_value    (value_chain[i]),
            .found_in      (found_chain[i]),
            .hit_value_in  (hval_chain[i]),
            .key           (key_chain[i+1]),
            .value         (value_chain[i+1]),
            .valid         (valid_vec[i]),
            .match         (match_vec[i]),
            .found_out     (found_chain[i+1]),
            .hit_value_out (hval_chain[i+1])
        );
    end

`ifndef SYNTHESIS
    // keys are unique among valid entries
    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lkv_pkg::ST_UPDATE |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(occ_reg))
        else $error("valid cells disagree with occupancy");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(occ_reg) <= N)
        else $error("occupancy above entry count");

    a_miss_value: assert property (@(posedge aclk) disable iff (!aresetn)
        finish && op_reg == lkv_pkg::OP_GET && !hit |=>
            m_tvalid && !m_tuser && m_tdata == lkv_pkg::MISS_VALUE)
        else $error("miss word not formed correctly");
`endif

endmodule

[rtl/lkv_cell.sv]
module lkv_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [lkv_pkg::IDX_W-1:0]  cell_idx,
    input  lkv_pkg::lkv_cmd_t          cmd,
    input  logic [lkv_pkg::KEY_W-1:0]  prev_key,
    input  logic [lkv_pkg::VAL_W-1:0]  prev_value,
    input  logic                       found_in,
    input  logic [lkv_pkg::VAL_W-1:0]  hit_value_in,
    output logic [lkv_pkg::KEY_W-1:0]  key,
    output logic [lkv_pkg::VAL_W-1:0]  value,
    output logic                       valid,
    output logic                       match,
    output logic                       found_out,
    output logic [lkv_pkg::VAL_W-1:0]  hit_value_out
);

    logic [lkv_pkg::KEY_W-1:0] key_reg;
    logic [lkv_pkg::VAL_W-1:0] value_reg;
    logic                      valid_reg, valid_next;
    logic                      match_reg, match_next;
    logic                      in_limit;
    logic                      shift_en;

    assign in_limit = (lkv_pkg::OCC_W'(cell_idx) <= cmd.limit);

    // on a hit, every cell up to and including the matching one takes its neighbor's entry
    assign shift_en = cmd.update & (cmd.hit ? ~found_in : in_limit);

    always_comb begin
        match_next = match_reg;
        if (cmd.compare) begin
            match_next = valid_reg & (key_reg == cmd.key);
        end
        valid_next = valid_reg;
        if (cmd.update && !cmd.hit) begin
            valid_next = in_limit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign key           = key_reg;
    assign value         = value_reg;
    assign valid         = valid_reg;
    assign match         = match_reg;
    assign found_out     = found_in | match_reg;
    assign hit_value_out = hit_value_in | (match_reg ? value_reg : '0);

endmodule
